>>> rtl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared widths, register indexes, reset values and types of the linear
// interpolation resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

  // field and register widths
  localparam int RATE_W     = 18;
  localparam int CAP_W      = 16;
  localparam int SAMP_W     = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // parameter defaults
  localparam int MAX_RUN_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAPACITY = 2'd2;

  // register reset values
  localparam logic [RATE_W-1:0] SOURCE_RATE_RST    = 18'd24000;
  localparam logic [RATE_W-1:0] TARGET_RATE_RST    = 18'd16000;
  localparam logic [CAP_W-1:0]  FRAME_CAPACITY_RST = 16'd960;

  // saturation value of the input position counter
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // effective configuration handed to the sequencer
  typedef struct packed {
    logic [RATE_W-1:0] src;
    logic [RATE_W-1:0] dst;
    logic [CAP_W-1:0]  cap;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic [SAMP_W-1:0] sample;
    logic              sample_valid;
    logic              frame_end;
    logic              run_end;
  } res_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> rtl/linear_interp_resampler_unit.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Linear interpolation sample rate converter over framed 16-bit audio.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed source sample per word, in_tlast on the last of a frame.
//   out_* : interpolated samples; out_tuser[0] flags a real sample (0 on a
//           frame-end marker), out_tuser[1] flags the last word caused by an
//           input word, out_tlast flags the last word of a frame.
//   cfg_* : register writes (source rate, target rate, frame capacity), taken
//           every cycle; write only while the block is idle.
// Throughput: one input word at a time. Each output takes a divider pass
//   plus the check, multiply and emit steps, and a frame end adds a division
//   for the limit; the next word is taken once the word's run completes.
// Each result is held back until the next position is resolved or the run ends.
// Reset clears frame position and the previous sample and loads the default
//   rates (24000 -> 16000) and capacity (960).
// A stalled receiver holds the result in the output register; the sequencer
//   waits for it and input stays blocked until the word's run completes.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit import lirs_pkg::*; #(
  parameter int MAX_RUN   = MAX_RUN_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [15:0] in_sample
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMP_W-1:0]     in_tdata,
  input  logic                  in_tlast,
  // out_tdata: [15:0] out_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMP_W-1:0]     out_tdata,
  output logic                  out_tlast,
  // out_tuser: [0] sample_valid, [1] run_end
  output logic [1:0]            out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DVD_W = RATE_W + CNT_W + FRAC_BITS;

  logic [RATE_W-1:0] src_r, dst_r;
  logic [CAP_W-1:0]  cap_r;
  cfg_t              cfg;
  logic              push_valid, push_ready;
  res_t              push_res;
  logic              out_vld_r;
  res_t              out_res_r;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend, div_quot;
  logic [RATE_W-1:0] div_divisor;
  div_sts_t          div_sts;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= SOURCE_RATE_RST;
      dst_r <= TARGET_RATE_RST;
      cap_r <= FRAME_CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_RATE:    src_r <= cfg_data[RATE_W-1:0];
        REG_TARGET_RATE:    dst_r <= cfg_data[RATE_W-1:0];
        REG_FRAME_CAPACITY: cap_r <= cfg_data[CAP_W-1:0];
        default:            ;
      endcase
    end
  end

  // a zero rate acts as one
  always_comb begin
    cfg.src = (src_r == '0) ? RATE_W'(1) : src_r;
    cfg.dst = (dst_r == '0) ? RATE_W'(1) : dst_r;
    cfg.cap = cap_r;
  end

  lirs_div #(
    .DVD_W (DVD_W),
    .DVS_W (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  lirs_seq #(
    .MAX_RUN   (MAX_RUN),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_sample    (in_tdata),
    .in_last      (in_tlast),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_res     (push_res),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_sts      (div_sts),
    .div_quot     (div_quot)
  );

  // output register
  assign push_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push_ready) begin
      out_vld_r <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      out_res_r <= push_res;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_res_r.sample;
  assign out_tlast    = out_res_r.frame_end;
  assign out_tuser[0] = out_res_r.sample_valid;
  assign out_tuser[1] = out_res_r.run_end;

`ifndef SYNTHESIS
  // a frame end always closes the run of its input word
  a_frame_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tlast || out_tuser[1]))
    else $error("frame end without run end");

  // a marker word only appears at frame end and carries zero
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && (out_tdata == '0)))
    else $error("malformed frame-end marker");

  // no input word is taken while a division is in flight
  a_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !div_sts.busy)
    else $error("input accepted while divider busy");

  // a push never happens while the divider works
  a_push_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (!div_sts.busy && !div_start))
    else $error("result pushed during division");
`endif

endmodule

>>> rtl/lirs_div.sv
// ----------------------------------------------------------------------------
// lirs_div
// Restoring serial divider, one quotient bit per cycle, shared by the limit
// and position calculations.
// ----------------------------------------------------------------------------
module lirs_div import lirs_pkg::*; #(
  parameter int DVD_W = RATE_W + CNT_W + FRAC_BITS_DEF,
  parameter int DVS_W = RATE_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [DVD_W-1:0] quot
);

  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [DVD_W-1:0]    quo_r;
  logic [DVS_W-1:0]    dvs_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r, done_r;
  logic [DVS_W:0]      trial, trial_sub;
  logic                take;

  // trial subtract of one step
  always_comb begin
    trial     = {rem_r, quo_r[DVD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    take      = (trial >= {1'b0, dvs_r});
    rem_nxt   = take ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_BITS'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], take};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = quo_r;

endmodule

>>> rtl/lirs_seq.sv
// ----------------------------------------------------------------------------
// lirs_seq
// Sequencer of the resampler: frame state, output position stepping,
// shared multiplier and interpolation, result ordering.
// ----------------------------------------------------------------------------
module lirs_seq import lirs_pkg::*; #(
  parameter int MAX_RUN   = MAX_RUN_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cfg_t                                 cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMP_W-1:0]                    in_sample,
  input  logic                                 in_last,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output res_t                                 push_res,
  output logic                                 div_start,
  output logic [RATE_W+CNT_W+FRAC_BITS-1:0]    div_dividend,
  output logic [RATE_W-1:0]                    div_divisor,
  input  div_sts_t                             div_sts,
  input  logic [RATE_W+CNT_W+FRAC_BITS-1:0]    div_quot
);

  localparam int DVD_W = RATE_W + CNT_W + FRAC_BITS;
  localparam int IDX_W = RATE_W + CNT_W;
  localparam int MA_W  = CNT_W + 3;
  localparam int MB_W  = ((FRAC_BITS > RATE_W) ? FRAC_BITS : RATE_W) + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int K_W   = $clog2(MAX_RUN + 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_WMUL    = 10'b0000000010,
    S_WDIV_GO = 10'b0000000100,
    S_WDIV    = 10'b0000001000,
    S_CHECK   = 10'b0000010000,
    S_PDIV_GO = 10'b0000100000,
    S_PDIV    = 10'b0001000000,
    S_IMUL    = 10'b0010000000,
    S_EMIT    = 10'b0100000000,
    S_FIN     = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SAMP_W-1:0]   cur_r, prior_r, val_r, pend_r;
  logic                last_r, pend_vld_r;
  logic [CNT_W-1:0]    ic_r, oc_r;
  logic [CAP_W-1:0]    limit_r;
  logic [K_W-1:0]      k_r;
  logic signed [P_W-1:0]  prod_r;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic [SAMP_W:0]     diff;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    ic_ext;
  logic                idx_lt, idx_eq;
  logic                whole_lt_cap;
  logic                in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // position decode of the quotient
  assign idx    = div_quot[DVD_W-1:FRAC_BITS];
  assign ic_ext = IDX_W'(ic_r);
  assign idx_lt = (idx < ic_ext);
  assign idx_eq = (idx == ic_ext);
  assign diff   = {cur_r[SAMP_W-1], cur_r} - {prior_r[SAMP_W-1], prior_r};
  assign whole_lt_cap = (div_quot[DVD_W-1:CAP_W] == '0) && (div_quot[CAP_W-1:0] < cfg.cap);

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_WMUL: begin
        mul_a = MA_W'({1'b0, ic_r} + (CNT_W + 1)'(1));
        mul_b = MB_W'(cfg.dst);
      end
      S_PDIV: begin
        mul_a = MA_W'($signed(diff));
        mul_b = MB_W'(div_quot[FRAC_BITS-1:0]);
      end
      default: begin
        mul_a = MA_W'(oc_r);
        mul_b = MB_W'(cfg.src);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // divider requests
  always_comb begin
    div_start    = (state_r == S_WDIV_GO) || (state_r == S_PDIV_GO);
    div_dividend = '0;
    div_divisor  = cfg.dst;
    if (state_r == S_WDIV_GO) begin
      div_dividend = DVD_W'(prod_r[RATE_W+CNT_W:0]);
      div_divisor  = cfg.src;
    end else begin
      div_dividend = {prod_r[IDX_W-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  // result push
  always_comb begin
    push_valid = 1'b0;
    push_res   = '0;
    if (state_r == S_EMIT) begin
      push_valid            = pend_vld_r;
      push_res.sample       = pend_r;
      push_res.sample_valid = 1'b1;
    end else if (state_r == S_FIN) begin
      push_valid            = pend_vld_r || last_r;
      push_res.sample       = pend_vld_r ? pend_r : '0;
      push_res.sample_valid = pend_vld_r;
      push_res.frame_end    = last_r;
      push_res.run_end      = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_acc) state_nxt = in_last ? S_WMUL : S_CHECK;
      S_WMUL:    state_nxt = S_WDIV_GO;
      S_WDIV_GO: state_nxt = S_WDIV;
      S_WDIV:    if (div_sts.done) state_nxt = S_CHECK;
      S_CHECK: begin
        if ((k_r < K_W'(MAX_RUN)) && (oc_r < limit_r)) state_nxt = S_PDIV_GO;
        else state_nxt = S_FIN;
      end
      S_PDIV_GO: state_nxt = S_PDIV;
      S_PDIV: begin
        if (div_sts.done) begin
          priority if (idx_lt) state_nxt = S_IMUL;
          else if (last_r && idx_eq) state_nxt = S_EMIT;
          else state_nxt = S_FIN;
        end
      end
      S_IMUL:    state_nxt = S_EMIT;
      S_EMIT:    if (!pend_vld_r || push_ready) state_nxt = S_CHECK;
      S_FIN:     if (!push_valid || push_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      prior_r    <= '0;
      ic_r       <= '0;
      oc_r       <= '0;
      pend_vld_r <= 1'b0;
      k_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        k_r <= '0;
      end
      if ((state_r == S_EMIT) && (state_nxt == S_CHECK)) begin
        pend_vld_r <= 1'b1;
        k_r        <= k_r + K_W'(1);
        oc_r       <= oc_r + CNT_W'(1);
      end
      // end of item: advance frame position
      if ((state_r == S_FIN) && (state_nxt == S_IDLE)) begin
        pend_vld_r <= 1'b0;
        prior_r    <= cur_r;
        if (last_r) begin
          ic_r <= '0;
          oc_r <= '0;
        end else if (ic_r != CNT_MAX) begin
          ic_r <= ic_r + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r   <= in_sample;
      last_r  <= in_last;
      limit_r <= cfg.cap;
    end
    if ((state_r == S_WDIV) && div_sts.done && whole_lt_cap) begin
      limit_r <= div_quot[CAP_W-1:0];
    end
    if ((state_r == S_PDIV) && div_sts.done) begin
      val_r <= cur_r;
    end
    if (state_r == S_IMUL) begin
      val_r <= prior_r + prod_r[FRAC_BITS +: SAMP_W];
    end
    if ((state_r == S_EMIT) && (state_nxt == S_CHECK)) begin
      pend_r <= val_r;
    end
  end

endmodule

>>> test/linear_interp_resampler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit_tb
// Streams framed signed samples through the resampler under a range of rate
// and capacity settings. Every input word is run through a local model of
// the interpolator, and every output word is checked field by field against
// that model. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit_tb;
  import lirs_pkg::*;

  localparam int     MAX_RUN     = MAX_RUN_DEF;
  localparam int     FRAC_BITS   = FRAC_BITS_DEF;
  localparam longint FRAC_MASK   = (64'd1 << FRAC_BITS) - 1;
  localparam int     SETTLE      = 1200;
  localparam int     DRAIN       = 2000;
  localparam int     CYCLE_LIMIT = 1000000;

  // index past the register list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // one source word waiting for the driver
  typedef struct {
    logic [SAMP_W-1:0] sample;
    logic              last;
    int                gap;
    bit                hold;
  } feed_word_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [SAMP_W-1:0]     in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SAMP_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // model registers and frame state
  logic [RATE_W-1:0] src_rate  = SOURCE_RATE_RST;
  logic [RATE_W-1:0] dst_rate  = TARGET_RATE_RST;
  logic [CAP_W-1:0]  cap_reg   = FRAME_CAPACITY_RST;
  logic [SAMP_W-1:0] prior_smp = '0;
  longint            in_pos    = 0;
  longint            out_pos   = 0;

  feed_word_t        sample_feed[$];
  res_t              interp_due[$];

  bit                calm       = 1'b0;
  logic [SAMP_W-1:0] smooth_smp = '0;
  int                gap_left   = -1;
  int                rdy_wait   = 0;
  int                n_queued   = 0;
  int                n_accepted = 0;
  int                n_frames   = 0;
  int                n_samples  = 0;
  int                n_markers  = 0;
  int                n_cfg      = 0;
  int                errors     = 0;
  int                cycles     = 0;

  linear_interp_resampler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_draw();
    if (calm) return 0;
    return $urandom_range(0, 13);
  endfunction

  // output words caused by one accepted source word
  task automatic resample_word(input logic [SAMP_W-1:0] word, input logic last);
    longint src, dst, lim, whole, pos, idx, n, s0, s1, step, acc;
    int     k;
    bit     stop;
    res_t   r;
    res_t   run_q[$];
    src = (src_rate == '0) ? 1 : longint'(src_rate);
    dst = (dst_rate == '0) ? 1 : longint'(dst_rate);
    n   = in_pos;
    lim = longint'(cap_reg);
    s0  = $signed(prior_smp);
    s1  = $signed(word);
    // at frame end the count is also bounded by the frame length
    if (last) begin
      whole = ((n + 1) * dst) / src;
      if (whole < lim) lim = whole;
    end
    k    = 0;
    stop = 1'b0;
    while (!stop && k < MAX_RUN && out_pos < lim) begin
      pos = ((out_pos * src) << FRAC_BITS) / dst;
      idx = pos >>> FRAC_BITS;
      r   = '0;
      if (idx < n) begin
        // lagging positions also land here and use the current pair
        step     = ((s1 - s0) * (pos & FRAC_MASK)) >>> FRAC_BITS;
        acc      = s0 + step;
        r.sample = acc[SAMP_W-1:0];
      end else if (last && idx == n) begin
        r.sample = word;
      end else begin
        stop = 1'b1;
      end
      if (!stop) begin
        r.sample_valid = 1'b1;
        run_q.push_back(r);
        k++;
        out_pos++;
      end
    end
    // frame end with nothing to emit gives a marker word
    if (last && k == 0) begin
      r = '0;
      run_q.push_back(r);
    end
    if (run_q.size() > 0) begin
      r = run_q.pop_back();
      r.run_end   = 1'b1;
      r.frame_end = last;
      run_q.push_back(r);
    end
    foreach (run_q[i]) interp_due.push_back(run_q[i]);
    prior_smp = word;
    if (last) begin
      in_pos  = 0;
      out_pos = 0;
    end else if (in_pos < longint'(CNT_MAX)) begin
      in_pos++;
    end
  endtask

  // source driver
  always @(posedge clk) begin : drv
    bit         vld;
    feed_word_t w;
    vld = in_tvalid;
    if (!rst_n) begin
      vld = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        resample_word(in_tdata, in_tlast);
        if (in_tlast) n_frames++;
        n_accepted++;
        vld = 1'b0;
      end
      if (!vld && sample_feed.size() > 0) begin
        if (gap_left < 0) gap_left = sample_feed[0].gap;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!sample_feed[0].hold || interp_due.size() == 0) begin
          w = sample_feed.pop_front();
          in_tdata <= w.sample;
          in_tlast <= w.last;
          vld      = 1'b1;
          gap_left = -1;
        end
      end
    end
    in_tvalid <= vld;
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : mon
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (interp_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual sample %0d user %b last %b",
                   $time, $signed(out_tdata), out_tuser, out_tlast);
          errors++;
        end else begin
          want = interp_due.pop_front();
          if (out_tdata !== want.sample) begin
            $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                     $time, $signed(want.sample), $signed(out_tdata));
            errors++;
          end
          if (out_tuser[0] !== want.sample_valid) begin
            $display("%0t: sample_valid mismatch, expected %b, actual %b",
                     $time, want.sample_valid, out_tuser[0]);
            errors++;
          end
          if (out_tlast !== want.frame_end) begin
            $display("%0t: frame_end mismatch, expected %b, actual %b",
                     $time, want.frame_end, out_tlast);
            errors++;
          end
          if (out_tuser[1] !== want.run_end) begin
            $display("%0t: run_end mismatch, expected %b, actual %b",
                     $time, want.run_end, out_tuser[1]);
            errors++;
          end
          if (want.sample_valid) n_samples++;
          else n_markers++;
        end
        rdy_wait = idle_draw();
      end
      if (rdy_wait > 0) begin
        rdy_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_word(input logic [SAMP_W-1:0] sample, input logic last,
                            input bit hold);
    feed_word_t w;
    w.sample = sample;
    w.last   = last;
    w.gap    = idle_draw();
    w.hold   = hold;
    sample_feed.push_back(w);
    n_queued++;
  endtask

  // wait for every word to be taken and answered, then for the block to settle
  task automatic settle();
    while (n_accepted != n_queued || interp_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SOURCE_RATE:    src_rate = val;
      REG_TARGET_RATE:    dst_rate = val;
      REG_FRAME_CAPACITY: cap_reg  = val[CAP_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic write_settings(input logic [RATE_W-1:0] src, input logic [RATE_W-1:0] dst,
                                input logic [CAP_W-1:0] cap);
    write_reg(REG_SOURCE_RATE, src);
    write_reg(REG_TARGET_RATE, dst);
    write_reg(REG_FRAME_CAPACITY, {2'b00, cap});
  endtask

  function automatic logic [SAMP_W-1:0] draw_sample();
    case ($urandom_range(0, 3))
      0: draw_sample = SAMP_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       draw_sample = 16'h7FFF;
          1:       draw_sample = 16'h8000;
          2:       draw_sample = 16'h0000;
          default: draw_sample = 16'hFFFF;
        endcase
      end
      default: begin
        // small steps, as real audio would give
        smooth_smp  = SAMP_W'(smooth_smp + $urandom_range(0, 128) - 32'd64);
        draw_sample = smooth_smp;
      end
    endcase
  endfunction

  // random frames; one word waits for the output to drain first
  task automatic queue_frames(input int total);
    int   i, len;
    logic last;
    i = 0;
    while (i < total) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(9, 30);
        1, 2:    len = 1;
        default: len = $urandom_range(2, 8);
      endcase
      for (int j = 0; j < len && i < total; j++) begin
        last = (j == len - 1) || (i == total - 1);
        // stray or missing frame ends
        if (i != total - 1 && $urandom_range(0, 15) == 0) last = ~last;
        queue_word(draw_sample(), last, i == total / 3);
        i++;
      end
    end
  endtask

  task automatic random_settings();
    logic [RATE_W-1:0] s, d;
    logic [CAP_W-1:0]  c;
    case ($urandom_range(0, 4))
      0:       s = 18'd1;
      1:       s = 18'd192000;
      2:       s = 18'h3FFFF;
      3:       s = RATE_W'($urandom_range(1, 24000));
      default: s = RATE_W'($urandom_range(1, 192000));
    endcase
    case ($urandom_range(0, 4))
      0:       d = (s <= 18'd24000) ? RATE_W'(s * $urandom_range(1, 8))
                                    : RATE_W'(s / $urandom_range(1, 6));
      1:       d = 18'd1;
      2:       d = 18'd192000;
      default: d = RATE_W'($urandom_range(1, 192000));
    endcase
    case ($urandom_range(0, 4))
      0:       c = 16'hFFFF;
      1:       c = CAP_W'($urandom_range(1, 4));
      2:       c = CAP_W'($urandom);
      default: c = CAP_W'($urandom_range(1, 64));
    endcase
    write_settings(s, d, c);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
  endtask

  // stimulus and end of run
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset rates: extremes of the sample and a single-word frame
    queue_word(16'h7FFF, 1'b0, 1'b0);
    queue_word(16'h8000, 1'b0, 1'b0);
    queue_word(16'h7FFF, 1'b0, 1'b0);
    queue_word(16'h8000, 1'b0, 1'b0);
    queue_word(16'h0000, 1'b0, 1'b0);
    queue_word(16'hFFFF, 1'b1, 1'b0);
    queue_word(16'h1234, 1'b1, 1'b0);
    settle();

    // upsampling past the run limit, lagging outputs, full capacity
    write_settings(18'd1000, 18'd9000, 16'hFFFF);
    queue_word(16'h0064, 1'b0, 1'b0);
    queue_word(16'hFF38, 1'b0, 1'b0);
    queue_word(16'h5555, 1'b0, 1'b0);
    queue_word(16'hAAAA, 1'b1, 1'b0);
    settle();

    // zero rates act as one, zero capacity gives markers only
    write_settings(18'd0, 18'd0, 16'd0);
    write_reg(REG_SPARE, 18'h3FFFF);
    queue_word(16'h0005, 1'b0, 1'b0);
    queue_word(16'h0007, 1'b1, 1'b0);
    settle();

    // widest source rate, narrowest target, capacity one
    write_settings(18'h3FFFF, 18'd1, 16'd1);
    queue_word(16'h0001, 1'b0, 1'b0);
    queue_word(16'h0002, 1'b0, 1'b0);
    queue_word(16'h0003, 1'b1, 1'b0);
    settle();

    // random phases, the first back at reset settings, one without idling
    for (int p = 0; p < 5; p++) begin
      calm = (p == 2);
      if (p == 0) write_settings(SOURCE_RATE_RST, TARGET_RATE_RST, FRAME_CAPACITY_RST);
      else random_settings();
      queue_frames(30);
      settle();
    end

    calm = 1'b0;
    while (n_accepted != n_queued || interp_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d source words in %0d frames across %0d register writes",
             n_accepted, n_frames, n_cfg);
    $display("checked %0d interpolated samples and %0d frame-end markers",
             n_samples, n_markers);
    if (errors == 0 && interp_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
